[src/stick_gesture_calibration_fsm_defines.svh]
// assertion macros for the stick gesture calibration block
`ifndef STICK_GESTURE_CALIBRATION_FSM_DEFINES_SVH
`define STICK_GESTURE_CALIBRATION_FSM_DEFINES_SVH

// checked only outside reset
`define SGC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sgc assertion failed");

// checked during reset as well
`define SGC_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sgc reset assertion failed");

`endif

[src/sgc_pkg.sv]
package sgc_pkg;

  localparam int unsigned USW  = 12;
  localparam int unsigned HTW  = 16;
  localparam int unsigned TSW  = 32;
  localparam int unsigned IDXW = 3;
  localparam int unsigned CFGW = 16;
  localparam int unsigned IN_TDATA_W  = 88;
  localparam int unsigned OUT_TDATA_W = 16;

  // register indexes
  localparam logic [IDXW-1:0] REG_LOW_THR  = 3'd0;
  localparam logic [IDXW-1:0] REG_HIGH_THR = 3'd1;
  localparam logic [IDXW-1:0] REG_HOLD     = 3'd2;
  localparam logic [IDXW-1:0] REG_ACK      = 3'd3;
  localparam logic [IDXW-1:0] REG_ERROR    = 3'd4;

  localparam logic [USW-1:0] LOW_THR_RST  = 12'd1150;
  localparam logic [USW-1:0] HIGH_THR_RST = 12'd1850;
  localparam logic [HTW-1:0] HOLD_RST     = 16'd800;
  localparam logic [HTW-1:0] ACK_RST      = 16'd1200;
  localparam logic [HTW-1:0] ERROR_RST    = 16'd1500;

  // result codes
  localparam logic [1:0] RES_NONE     = 2'd0;
  localparam logic [1:0] RES_RELEASED = 2'd1;
  localparam logic [1:0] RES_SAVED    = 2'd2;
  localparam logic [1:0] RES_ERROR    = 2'd3;

  // failing operation codes
  localparam logic [1:0] OP_NONE    = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_RESTORE = 2'd2;
  localparam logic [1:0] OP_SAVE    = 2'd3;

  // mode codes as they appear on the result
  localparam logic [1:0] MC_IDLE     = 2'd0;
  localparam logic [1:0] MC_RELEASED = 2'd1;
  localparam logic [1:0] MC_ACK      = 2'd2;
  localparam logic [1:0] MC_ERROR    = 2'd3;

  localparam logic [1:0] SERVO_NONE = 2'd0;
  localparam logic [1:0] SERVO_1    = 2'd1;
  localparam logic [1:0] SERVO_2    = 2'd2;

  typedef enum logic [3:0] {
    MODE_IDLE     = 4'b0001,
    MODE_RELEASED = 4'b0010,
    MODE_ACK      = 4'b0100,
    MODE_ERROR    = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [USW-1:0] low_thr;
    logic [USW-1:0] high_thr;
    logic [HTW-1:0] hold_ms;
    logic [HTW-1:0] ack_ms;
    logic [HTW-1:0] error_ms;
  } cfg_t;

  typedef struct packed {
    logic [USW-1:0] roll_us;
    logic [USW-1:0] pitch_us;
    logic [USW-1:0] throttle_us;
    logic [USW-1:0] yaw_us;
    logic           link_ok;
    logic           arm_high;
    logic [TSW-1:0] now_ms;
    logic           servo1_op_ok;
    logic           servo2_op_ok;
    logic           restore1_ok;
    logic           restore2_ok;
  } item_t;

  typedef struct packed {
    mode_t          mode;
    logic [TSW-1:0] release_hold_start;
    logic [TSW-1:0] save_hold_start;
    logic [TSW-1:0] transient_start;
  } state_t;

  typedef struct packed {
    logic [1:0] result_code;
    logic [1:0] mode;
    logic       active;
    logic       release_cmd;
    logic       save_cmd;
    logic       restore_cmd;
    logic [1:0] fail_servo;
    logic [1:0] fail_op;
  } result_t;

  function automatic logic [1:0] mode_code(input mode_t m);
    logic [1:0] c;
    unique case (m)
      MODE_IDLE:     c = MC_IDLE;
      MODE_RELEASED: c = MC_RELEASED;
      MODE_ACK:      c = MC_ACK;
      MODE_ERROR:    c = MC_ERROR;
      default:       c = MC_IDLE;
    endcase
    return c;
  endfunction

endpackage

[src/sgc_cfg_regs.sv]
module sgc_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [sgc_pkg::IDXW-1:0]    cfg_index,
  input  logic [sgc_pkg::CFGW-1:0]    cfg_wdata,
  output sgc_pkg::cfg_t               cfg
);

  sgc_pkg::cfg_t cfg_r;
  sgc_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        sgc_pkg::REG_LOW_THR:  cfg_nxt.low_thr  = cfg_wdata[sgc_pkg::USW-1:0];
        sgc_pkg::REG_HIGH_THR: cfg_nxt.high_thr = cfg_wdata[sgc_pkg::USW-1:0];
        sgc_pkg::REG_HOLD:     cfg_nxt.hold_ms  = cfg_wdata[sgc_pkg::HTW-1:0];
        sgc_pkg::REG_ACK:      cfg_nxt.ack_ms   = cfg_wdata[sgc_pkg::HTW-1:0];
        sgc_pkg::REG_ERROR:    cfg_nxt.error_ms = cfg_wdata[sgc_pkg::HTW-1:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_thr  <= sgc_pkg::LOW_THR_RST;
      cfg_r.high_thr <= sgc_pkg::HIGH_THR_RST;
      cfg_r.hold_ms  <= sgc_pkg::HOLD_RST;
      cfg_r.ack_ms   <= sgc_pkg::ACK_RST;
      cfg_r.error_ms <= sgc_pkg::ERROR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[src/sgc_step.sv]
module sgc_step (
  input  sgc_pkg::item_t   item,
  input  sgc_pkg::cfg_t    cfg,
  input  sgc_pkg::state_t  st,
  output sgc_pkg::state_t  st_nxt,
  output sgc_pkg::result_t res
);

  logic thr_low, yaw_low, yaw_high, pitch_low, roll_low, roll_high;
  logic gate, rel_gesture, save_gesture;
  logic ack_done, err_done, rel_held, save_held;
  logic [sgc_pkg::TSW-1:0] now;
  sgc_pkg::mode_t mode_n;

  assign now       = item.now_ms;
  assign thr_low   = item.throttle_us <= cfg.low_thr;
  assign yaw_low   = item.yaw_us <= cfg.low_thr;
  assign yaw_high  = item.yaw_us >= cfg.high_thr;
  assign pitch_low = item.pitch_us <= cfg.low_thr;
  assign roll_low  = item.roll_us <= cfg.low_thr;
  assign roll_high = item.roll_us >= cfg.high_thr;

  assign gate         = item.link_ok && !item.arm_high && thr_low;
  assign rel_gesture  = thr_low && yaw_low && pitch_low && roll_high;
  assign save_gesture = thr_low && yaw_high && pitch_low && roll_low;

  // elapsed times wrap modulo 2^32
  assign ack_done  = (now - st.transient_start) >= {16'd0, cfg.ack_ms};
  assign err_done  = (now - st.transient_start) >= {16'd0, cfg.error_ms};
  assign rel_held  = (now - st.release_hold_start) >= {16'd0, cfg.hold_ms};
  assign save_held = (now - st.save_hold_start) >= {16'd0, cfg.hold_ms};

  always_comb begin
    st_nxt          = st;
    res.result_code = sgc_pkg::RES_NONE;
    res.release_cmd = 1'b0;
    res.save_cmd    = 1'b0;
    res.restore_cmd = 1'b0;
    res.fail_servo  = sgc_pkg::SERVO_NONE;
    res.fail_op     = sgc_pkg::OP_NONE;

    priority if (st.mode == sgc_pkg::MODE_ACK) begin
      if (ack_done) st_nxt.mode = sgc_pkg::MODE_IDLE;
    end else if (st.mode == sgc_pkg::MODE_ERROR) begin
      if (err_done) begin
        res.restore_cmd = 1'b1;
        st_nxt.mode     = sgc_pkg::MODE_IDLE;
      end
    end else if (!gate) begin
      st_nxt.release_hold_start = '0;
      st_nxt.save_hold_start    = '0;
      // leaving the gate while released aborts
      if (st.mode == sgc_pkg::MODE_RELEASED) begin
        res.restore_cmd = 1'b1;
        st_nxt.mode     = sgc_pkg::MODE_IDLE;
        res.result_code = sgc_pkg::RES_ERROR;
      end
    end else if (st.mode == sgc_pkg::MODE_IDLE) begin
      priority if (!rel_gesture) begin
        st_nxt.release_hold_start = '0;
      end else if (st.release_hold_start == '0) begin
        st_nxt.release_hold_start = now;
      end else if (rel_held) begin
        st_nxt.release_hold_start = '0;
        res.release_cmd = 1'b1;
        if (!item.servo1_op_ok || !item.servo2_op_ok) begin
          res.fail_servo         = item.servo1_op_ok ? sgc_pkg::SERVO_2 : sgc_pkg::SERVO_1;
          res.fail_op            = sgc_pkg::OP_RELEASE;
          st_nxt.mode            = sgc_pkg::MODE_ERROR;
          st_nxt.transient_start = now;
          res.result_code        = sgc_pkg::RES_ERROR;
        end else begin
          st_nxt.mode            = sgc_pkg::MODE_RELEASED;
          st_nxt.save_hold_start = '0;
          res.result_code        = sgc_pkg::RES_RELEASED;
        end
      end else begin
        // gesture still held, stamp kept
      end
    end else if (st.mode == sgc_pkg::MODE_RELEASED) begin
      priority if (!save_gesture) begin
        st_nxt.save_hold_start = '0;
      end else if (st.save_hold_start == '0) begin
        st_nxt.save_hold_start = now;
      end else if (save_held) begin
        st_nxt.save_hold_start = '0;
        st_nxt.transient_start = now;
        res.save_cmd           = 1'b1;
        if (!item.servo1_op_ok || !item.servo2_op_ok) begin
          // no restore after a failed save
          res.fail_servo = item.servo1_op_ok ? sgc_pkg::SERVO_2 : sgc_pkg::SERVO_1;
          res.fail_op    = sgc_pkg::OP_SAVE;
        end else begin
          res.restore_cmd = 1'b1;
          if (!item.restore1_ok || !item.restore2_ok) begin
            res.fail_servo = item.restore1_ok ? sgc_pkg::SERVO_2 : sgc_pkg::SERVO_1;
            res.fail_op    = sgc_pkg::OP_RESTORE;
          end
        end
        if (res.fail_op != sgc_pkg::OP_NONE) begin
          st_nxt.mode     = sgc_pkg::MODE_ERROR;
          res.result_code = sgc_pkg::RES_ERROR;
        end else begin
          st_nxt.mode     = sgc_pkg::MODE_ACK;
          res.result_code = sgc_pkg::RES_SAVED;
        end
      end else begin
        // gesture still held, stamp kept
      end
    end else begin
      st_nxt.mode = sgc_pkg::MODE_IDLE;
    end

    mode_n     = st_nxt.mode;
    res.mode   = sgc_pkg::mode_code(mode_n);
    res.active = mode_n != sgc_pkg::MODE_IDLE;
  end

endmodule

[src/stick_gesture_calibration_fsm.sv]
// Stick gesture calibration sequencer. One tick record enters on the in_ stream and
// exactly one result leaves on the out_ stream for each. A new tick is taken every
// clock cycle while out_ is not stalled; the tick is held in the input register, then
// its result in the result register, which offers it on out_ and holds it while the
// output is stalled.
// The rate is set by the mode and hold-stamp registers, whose next value is worked
// out combinationally from the registered tick. The user must see that registers are
// written through cfg_we/cfg_index/cfg_wdata only while no tick is in flight; the block does not enforce it.
module stick_gesture_calibration_fsm (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [sgc_pkg::IDXW-1:0]           cfg_index,
  input  logic [sgc_pkg::CFGW-1:0]           cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // roll_us, pitch_us, throttle_us, yaw_us, link_ok, arm_high, now_ms,
  // servo1_op_ok, servo2_op_ok, restore1_ok, restore2_ok, zero fill
  input  logic [sgc_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // result_code, mode, active, release_cmd, save_cmd, restore_cmd,
  // fail_servo, fail_op, zero fill
  output logic [sgc_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  sgc_pkg::cfg_t    cfg;
  sgc_pkg::item_t   in_item;
  sgc_pkg::item_t   item_r;
  logic             item_vld_r, item_vld_nxt;
  sgc_pkg::state_t  st_r, st_nxt;
  sgc_pkg::result_t res;
  sgc_pkg::result_t res_r;
  logic             out_vld_r, out_vld_nxt;
  logic             in_xfer, advance;

  sgc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign in_item.roll_us      = in_tdata[11:0];
  assign in_item.pitch_us     = in_tdata[23:12];
  assign in_item.throttle_us  = in_tdata[35:24];
  assign in_item.yaw_us       = in_tdata[47:36];
  assign in_item.link_ok      = in_tdata[48];
  assign in_item.arm_high     = in_tdata[49];
  assign in_item.now_ms       = in_tdata[81:50];
  assign in_item.servo1_op_ok = in_tdata[82];
  assign in_item.servo2_op_ok = in_tdata[83];
  assign in_item.restore1_ok  = in_tdata[84];
  assign in_item.restore2_ok  = in_tdata[85];

  // the tick moves on when the result register is free or draining
  assign advance   = item_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !item_vld_r || advance;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    item_vld_nxt = item_vld_r;
    if (in_xfer) item_vld_nxt = 1'b1;
    else if (advance) item_vld_nxt = 1'b0;
    out_vld_nxt = out_vld_r;
    if (advance) out_vld_nxt = 1'b1;
    else if (out_tready) out_vld_nxt = 1'b0;
  end

  sgc_step u_step (
    .item   (item_r),
    .cfg    (cfg),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r            <= 1'b0;
      out_vld_r             <= 1'b0;
      st_r.mode               <= sgc_pkg::MODE_IDLE;
      st_r.release_hold_start <= '0;
      st_r.save_hold_start    <= '0;
      st_r.transient_start    <= '0;
    end else begin
      item_vld_r <= item_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      if (advance) st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) item_r <= in_item;
    if (advance) res_r <= res;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'd0, res_r.fail_op, res_r.fail_servo, res_r.restore_cmd,
                       res_r.save_cmd, res_r.release_cmd, res_r.active, res_r.mode,
                       res_r.result_code};

endmodule

[src/sgc_checker.sv]
`include "stick_gesture_calibration_fsm_defines.svh"

module sgc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [sgc_pkg::OUT_TDATA_W-1:0] out_tdata
);

  `SGC_ASSERT_RST(a_rst_no_out, !rst_n |=> !out_tvalid)

  `SGC_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))

  `SGC_ASSERT(a_active_mode,
    out_tvalid |-> out_tdata[4] == (out_tdata[3:2] != sgc_pkg::MC_IDLE))

  `SGC_ASSERT(a_release_result,
    out_tvalid && out_tdata[5] |-> out_tdata[1:0] == sgc_pkg::RES_RELEASED || out_tdata[1:0] == sgc_pkg::RES_ERROR)

  `SGC_ASSERT(a_fail_pairs,
    out_tvalid |-> (out_tdata[9:8] == sgc_pkg::SERVO_NONE) == (out_tdata[11:10] == sgc_pkg::OP_NONE))

endmodule

bind stick_gesture_calibration_fsm sgc_checker u_sgc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[tb/sv/stick_gesture_calibration_fsm_tb.sv]
`timescale 1ns / 100ps

module stick_gesture_calibration_fsm_tb;

  localparam int NUM_PHASES   = 12;
  localparam int PHASE_ITEMS  = 152;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam logic [sgc_pkg::IDXW-1:0] REG_FIRST_UNUSED = sgc_pkg::REG_ERROR + 3'd1;

  typedef enum logic [1:0] {SEG_RELEASE, SEG_SAVE, SEG_NOISE, SEG_UNSAFE} seg_kind_t;

  typedef struct {
    sgc_pkg::item_t   tick;
    bit               typed;
    sgc_pkg::result_t want;
  } dir_row_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [sgc_pkg::IDXW-1:0]        cfg_index = '0;
  logic [sgc_pkg::CFGW-1:0]        cfg_wdata = '0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [sgc_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [sgc_pkg::OUT_TDATA_W-1:0] out_tdata;

  // sequencer copy: configuration and state
  logic [sgc_pkg::USW-1:0] thr_low, thr_high;
  logic [sgc_pkg::HTW-1:0] hold_ms, ack_ms, err_ms;
  logic [1:0]              cal_mode;
  logic [sgc_pkg::TSW-1:0] rel_stamp, save_stamp, trans_stamp;

  sgc_pkg::result_t calib_results_q[$];
  dir_row_t         directed_rows[$];
  sgc_pkg::result_t due_res, seen_res;
  int         mismatch_cnt = 0;
  int         cycle_cnt = 0;
  bit         calm = 1'b0;
  int         stall_left = 0;
  int         stall_gap;
  logic [sgc_pkg::TSW-1:0] tick_ms = '0;
  seg_kind_t  seg_kind = SEG_RELEASE;
  int         seg_left = 0;

  // phase setup scratch
  logic [sgc_pkg::USW-1:0]  new_low, new_high;
  logic [sgc_pkg::HTW-1:0]  new_hold, new_ack, new_err;
  logic [31:0]              rnd;
  logic [sgc_pkg::IDXW-1:0] spare_idx;

  stick_gesture_calibration_fsm dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt % 500 == 0) calm <= ($urandom_range(0, 3) == 0);
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      stall_gap = pick_gap();
      if (stall_gap == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        stall_left <= stall_gap - 1;
      end
    end
  end

  function automatic bit stick_low(input logic [sgc_pkg::USW-1:0] v);
    return v <= thr_low;
  endfunction

  function automatic bit stick_high(input logic [sgc_pkg::USW-1:0] v);
    return v >= thr_high;
  endfunction

  function automatic logic [sgc_pkg::TSW-1:0] since(input logic [sgc_pkg::TSW-1:0] now,
                                                    input logic [sgc_pkg::TSW-1:0] stamp);
    return now - stamp;
  endfunction

  function automatic sgc_pkg::result_t step_calibration(input sgc_pkg::item_t t);
    sgc_pkg::result_t r;
    bit               gate;
    bit               gesture;
    r = '0;
    gate = t.link_ok && !t.arm_high && stick_low(t.throttle_us);
    if (cal_mode == sgc_pkg::MC_ACK) begin
      if (since(t.now_ms, trans_stamp) >= ack_ms) cal_mode = sgc_pkg::MC_IDLE;
    end else if (cal_mode == sgc_pkg::MC_ERROR) begin
      if (since(t.now_ms, trans_stamp) >= err_ms) begin
        r.restore_cmd = 1'b1;
        cal_mode = sgc_pkg::MC_IDLE;
      end
    end else if (!gate) begin
      rel_stamp = '0;
      save_stamp = '0;
      // leaving the safe gate while released aborts
      if (cal_mode == sgc_pkg::MC_RELEASED) begin
        r.restore_cmd = 1'b1;
        cal_mode = sgc_pkg::MC_IDLE;
        r.result_code = sgc_pkg::RES_ERROR;
      end
    end else if (cal_mode == sgc_pkg::MC_IDLE) begin
      gesture = stick_low(t.throttle_us) && stick_low(t.yaw_us) &&
                stick_low(t.pitch_us) && stick_high(t.roll_us);
      if (!gesture) begin
        rel_stamp = '0;
      end else if (rel_stamp == '0) begin
        rel_stamp = t.now_ms;
      end else if (since(t.now_ms, rel_stamp) >= hold_ms) begin
        rel_stamp = '0;
        r.release_cmd = 1'b1;
        if (!t.servo1_op_ok || !t.servo2_op_ok) begin
          r.fail_servo = t.servo1_op_ok ? sgc_pkg::SERVO_2 : sgc_pkg::SERVO_1;
          r.fail_op = sgc_pkg::OP_RELEASE;
          cal_mode = sgc_pkg::MC_ERROR;
          trans_stamp = t.now_ms;
          r.result_code = sgc_pkg::RES_ERROR;
        end else begin
          cal_mode = sgc_pkg::MC_RELEASED;
          save_stamp = '0;
          r.result_code = sgc_pkg::RES_RELEASED;
        end
      end
    end else begin
      gesture = stick_low(t.throttle_us) && stick_high(t.yaw_us) &&
                stick_low(t.pitch_us) && stick_low(t.roll_us);
      if (!gesture) begin
        save_stamp = '0;
      end else if (save_stamp == '0) begin
        save_stamp = t.now_ms;
      end else if (since(t.now_ms, save_stamp) >= hold_ms) begin
        save_stamp = '0;
        r.save_cmd = 1'b1;
        if (!t.servo1_op_ok || !t.servo2_op_ok) begin
          // no restore after a failed save
          r.fail_servo = t.servo1_op_ok ? sgc_pkg::SERVO_2 : sgc_pkg::SERVO_1;
          r.fail_op = sgc_pkg::OP_SAVE;
        end else begin
          r.restore_cmd = 1'b1;
          if (!t.restore1_ok || !t.restore2_ok) begin
            r.fail_servo = t.restore1_ok ? sgc_pkg::SERVO_2 : sgc_pkg::SERVO_1;
            r.fail_op = sgc_pkg::OP_RESTORE;
          end
        end
        trans_stamp = t.now_ms;
        if (r.fail_op != sgc_pkg::OP_NONE) begin
          cal_mode = sgc_pkg::MC_ERROR;
          r.result_code = sgc_pkg::RES_ERROR;
        end else begin
          cal_mode = sgc_pkg::MC_ACK;
          r.result_code = sgc_pkg::RES_SAVED;
        end
      end
    end
    r.mode = cal_mode;
    r.active = (cal_mode != sgc_pkg::MC_IDLE);
    return r;
  endfunction

  function automatic logic [sgc_pkg::IN_TDATA_W-1:0] pack_tick(input sgc_pkg::item_t t);
    return {2'b00, t.restore2_ok, t.restore1_ok, t.servo2_op_ok, t.servo1_op_ok,
            t.now_ms, t.arm_high, t.link_ok, t.yaw_us, t.throttle_us, t.pitch_us, t.roll_us};
  endfunction

  function automatic sgc_pkg::result_t unpack_result(input logic [sgc_pkg::OUT_TDATA_W-1:0] d);
    sgc_pkg::result_t r;
    r.result_code = d[1:0];
    r.mode        = d[3:2];
    r.active      = d[4];
    r.release_cmd = d[5];
    r.save_cmd    = d[6];
    r.restore_cmd = d[7];
    r.fail_servo  = d[9:8];
    r.fail_op     = d[11:10];
    return r;
  endfunction

  function automatic int field_mismatch(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (calib_results_q.size() == 0) begin
        $error("result transfer with nothing pending: tdata %h", out_tdata);
        mismatch_cnt = mismatch_cnt + 1;
      end else begin
        due_res = calib_results_q.pop_front();
        seen_res = unpack_result(out_tdata);
        mismatch_cnt = mismatch_cnt +
          field_mismatch("result_code", due_res.result_code, seen_res.result_code) +
          field_mismatch("mode", due_res.mode, seen_res.mode) +
          field_mismatch("active", due_res.active, seen_res.active) +
          field_mismatch("release_cmd", due_res.release_cmd, seen_res.release_cmd) +
          field_mismatch("save_cmd", due_res.save_cmd, seen_res.save_cmd) +
          field_mismatch("restore_cmd", due_res.restore_cmd, seen_res.restore_cmd) +
          field_mismatch("fail_servo", due_res.fail_servo, seen_res.fail_servo) +
          field_mismatch("fail_op", due_res.fail_op, seen_res.fail_op);
      end
    end
  end

  function automatic sgc_pkg::item_t mk_tick(input logic [sgc_pkg::USW-1:0] roll,
                                             input logic [sgc_pkg::USW-1:0] pitch,
                                             input logic [sgc_pkg::USW-1:0] thr,
                                             input logic [sgc_pkg::USW-1:0] yaw,
                                             input logic link, input logic arm,
                                             input logic [sgc_pkg::TSW-1:0] now,
                                             input logic op1, input logic op2,
                                             input logic rs1, input logic rs2);
    sgc_pkg::item_t t;
    t.roll_us = roll;
    t.pitch_us = pitch;
    t.throttle_us = thr;
    t.yaw_us = yaw;
    t.link_ok = link;
    t.arm_high = arm;
    t.now_ms = now;
    t.servo1_op_ok = op1;
    t.servo2_op_ok = op2;
    t.restore1_ok = rs1;
    t.restore2_ok = rs2;
    return t;
  endfunction

  function automatic sgc_pkg::item_t rel_tick(input logic [sgc_pkg::TSW-1:0] now,
                                              input logic op1, input logic op2);
    return mk_tick(12'd4095, 12'd0, 12'd0, 12'd0, 1'b1, 1'b0, now, op1, op2, 1'b1, 1'b1);
  endfunction

  function automatic sgc_pkg::item_t save_tick(input logic [sgc_pkg::TSW-1:0] now,
                                               input logic op1, input logic op2,
                                               input logic rs1, input logic rs2);
    return mk_tick(12'd0, 12'd0, 12'd0, 12'd4095, 1'b1, 1'b0, now, op1, op2, rs1, rs2);
  endfunction

  // safe gate open, sticks centered
  function automatic sgc_pkg::item_t centered_tick(input logic [sgc_pkg::TSW-1:0] now);
    return mk_tick(12'd1500, 12'd1500, 12'd0, 12'd1500, 1'b1, 1'b0, now,
                   1'b1, 1'b1, 1'b1, 1'b1);
  endfunction

  function automatic sgc_pkg::result_t mk_res(input logic [1:0] code, input logic [1:0] mode,
                                              input logic rel, input logic sav,
                                              input logic rst,
                                              input logic [1:0] fsrv, input logic [1:0] fop);
    sgc_pkg::result_t r;
    r.result_code = code;
    r.mode = mode;
    r.active = (mode != sgc_pkg::MC_IDLE);
    r.release_cmd = rel;
    r.save_cmd = sav;
    r.restore_cmd = rst;
    r.fail_servo = fsrv;
    r.fail_op = fop;
    return r;
  endfunction

  task automatic add_row(input sgc_pkg::item_t t, input bit typed, input sgc_pkg::result_t want);
    dir_row_t row;
    row.tick = t;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  function automatic logic [sgc_pkg::USW-1:0] pick_low();
    int          r;
    logic [31:0] v;
    r = $urandom_range(0, 9);
    if (r == 0) return thr_low;
    if (r == 1) return thr_low + 1'b1;
    v = $urandom_range(0, thr_low);
    return v[sgc_pkg::USW-1:0];
  endfunction

  function automatic logic [sgc_pkg::USW-1:0] pick_high();
    int          r;
    logic [31:0] v;
    r = $urandom_range(0, 9);
    if (r == 0) return thr_high;
    if (r == 1) return thr_high - 1'b1;
    v = $urandom_range(thr_high, 4095);
    return v[sgc_pkg::USW-1:0];
  endfunction

  function automatic sgc_pkg::item_t next_random_tick();
    sgc_pkg::item_t t;
    int             r;
    logic [31:0]    scale;
    logic [31:0]    v;
    scale = hold_ms;
    if (ack_ms > scale) scale = ack_ms;
    if (err_ms > scale) scale = err_ms;
    scale = scale / 2 + 2;
    r = $urandom_range(0, 99);
    if (r < 3) tick_ms = $urandom;
    else if (r < 5) tick_ms = '0;
    else if (r < 7) tick_ms = 32'hFFFF_FFFF - $urandom_range(0, scale);
    else tick_ms = tick_ms + $urandom_range(0, scale);
    if (seg_left == 0) begin
      // steer toward the gesture that moves the sequencer forward
      r = $urandom_range(0, 99);
      if (r < 15) seg_kind = SEG_NOISE;
      else if (r < 25) seg_kind = SEG_UNSAFE;
      else if (r < 75) seg_kind = (cal_mode == sgc_pkg::MC_RELEASED) ? SEG_SAVE : SEG_RELEASE;
      else seg_kind = (cal_mode == sgc_pkg::MC_RELEASED) ? SEG_RELEASE : SEG_SAVE;
      if (seg_kind == SEG_NOISE) seg_left = $urandom_range(1, 4);
      else if (seg_kind == SEG_UNSAFE) seg_left = $urandom_range(1, 3);
      else seg_left = $urandom_range(1, 12);
    end
    seg_left = seg_left - 1;
    t.now_ms = tick_ms;
    t.link_ok = ($urandom_range(0, 99) >= 2);
    t.arm_high = ($urandom_range(0, 99) < 2);
    t.servo1_op_ok = ($urandom_range(0, 99) >= 8);
    t.servo2_op_ok = ($urandom_range(0, 99) >= 8);
    t.restore1_ok = ($urandom_range(0, 99) >= 8);
    t.restore2_ok = ($urandom_range(0, 99) >= 8);
    t.pitch_us = pick_low();
    t.throttle_us = pick_low();
    if (seg_kind == SEG_SAVE) begin
      t.roll_us = pick_low();
      t.yaw_us = pick_high();
    end else begin
      t.roll_us = pick_high();
      t.yaw_us = pick_low();
    end
    if (seg_kind == SEG_NOISE) begin
      v = $urandom;
      t.roll_us = v[11:0];
      t.pitch_us = v[23:12];
      t.link_ok = v[24];
      t.arm_high = v[25];
      t.servo1_op_ok = v[26];
      t.servo2_op_ok = v[27];
      t.restore1_ok = v[28];
      t.restore2_ok = v[29];
      v = $urandom;
      t.throttle_us = v[11:0];
      t.yaw_us = v[23:12];
    end else if (seg_kind == SEG_UNSAFE) begin
      case ($urandom_range(0, 2))
        0: t.link_ok = 1'b0;
        1: t.arm_high = 1'b1;
        default: begin
          v = $urandom;
          t.throttle_us = v[11:0];
          t.arm_high = v[12];
        end
      endcase
    end
    return t;
  endfunction

  task automatic send_tick(input sgc_pkg::item_t t, input bit typed,
                           input sgc_pkg::result_t want);
    int               gap;
    sgc_pkg::result_t r;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= pack_tick(t);
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    r = step_calibration(t);
    calib_results_q.push_back(typed ? want : r);
  endtask

  task automatic write_reg(input logic [sgc_pkg::IDXW-1:0] idx,
                           input logic [sgc_pkg::CFGW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      sgc_pkg::REG_LOW_THR:  thr_low = val[sgc_pkg::USW-1:0];
      sgc_pkg::REG_HIGH_THR: thr_high = val[sgc_pkg::USW-1:0];
      sgc_pkg::REG_HOLD:     hold_ms = val;
      sgc_pkg::REG_ACK:      ack_ms = val;
      sgc_pkg::REG_ERROR:    err_ms = val;
      default:               ;
    endcase
  endtask

  task automatic wait_until_drained();
    in_tvalid <= 1'b0;
    while (calib_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    thr_low = sgc_pkg::LOW_THR_RST;
    thr_high = sgc_pkg::HIGH_THR_RST;
    hold_ms = sgc_pkg::HOLD_RST;
    ack_ms = sgc_pkg::ACK_RST;
    err_ms = sgc_pkg::ERROR_RST;
    cal_mode = sgc_pkg::MC_IDLE;
    rel_stamp = '0;
    save_stamp = '0;
    trans_stamp = '0;

    // directed part, reset configuration
    add_row(mk_tick(12'd0, 12'd0, 12'd0, 12'd0, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0),
            1, mk_res(sgc_pkg::RES_NONE, sgc_pkg::MC_IDLE, 1'b0, 1'b0, 1'b0,
                      sgc_pkg::SERVO_NONE, sgc_pkg::OP_NONE));
    add_row(mk_tick(12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1, 1'b1, 32'hFFFF_FFFF,
                    1'b1, 1'b1, 1'b1, 1'b1),
            1, mk_res(sgc_pkg::RES_NONE, sgc_pkg::MC_IDLE, 1'b0, 1'b0, 1'b0,
                      sgc_pkg::SERVO_NONE, sgc_pkg::OP_NONE));
    // gesture begun at stamp zero restarts on the next tick
    add_row(rel_tick(32'd0, 1'b1, 1'b1), 0, '0);
    add_row(rel_tick(32'd1000, 1'b1, 1'b1), 0, '0);
    add_row(rel_tick(32'd1799, 1'b1, 1'b1), 0, '0);
    add_row(rel_tick(32'd1800, 1'b1, 1'b1),
            1, mk_res(sgc_pkg::RES_RELEASED, sgc_pkg::MC_RELEASED, 1'b1, 1'b0, 1'b0,
                      sgc_pkg::SERVO_NONE, sgc_pkg::OP_NONE));
    add_row(save_tick(32'd2000, 1'b1, 1'b1, 1'b1, 1'b1), 0, '0);
    add_row(save_tick(32'd2800, 1'b1, 1'b1, 1'b1, 1'b1),
            1, mk_res(sgc_pkg::RES_SAVED, sgc_pkg::MC_ACK, 1'b0, 1'b1, 1'b1,
                      sgc_pkg::SERVO_NONE, sgc_pkg::OP_NONE));
    add_row(centered_tick(32'd4000), 0, '0);
    add_row(rel_tick(32'd5000, 1'b1, 1'b1), 0, '0);
    add_row(rel_tick(32'd5800, 1'b0, 1'b0),
            1, mk_res(sgc_pkg::RES_ERROR, sgc_pkg::MC_ERROR, 1'b1, 1'b0, 1'b0,
                      sgc_pkg::SERVO_1, sgc_pkg::OP_RELEASE));
    add_row(centered_tick(32'd7300),
            1, mk_res(sgc_pkg::RES_NONE, sgc_pkg::MC_IDLE, 1'b0, 1'b0, 1'b1,
                      sgc_pkg::SERVO_NONE, sgc_pkg::OP_NONE));
    add_row(rel_tick(32'd8000, 1'b1, 1'b1), 0, '0);
    add_row(rel_tick(32'd8800, 1'b1, 1'b0),
            1, mk_res(sgc_pkg::RES_ERROR, sgc_pkg::MC_ERROR, 1'b1, 1'b0, 1'b0,
                      sgc_pkg::SERVO_2, sgc_pkg::OP_RELEASE));
    add_row(centered_tick(32'd10300), 0, '0);
    add_row(rel_tick(32'd11000, 1'b1, 1'b1), 0, '0);
    add_row(rel_tick(32'd11800, 1'b1, 1'b1), 0, '0);
    add_row(save_tick(32'd12000, 1'b1, 1'b1, 1'b1, 1'b1), 0, '0);
    add_row(save_tick(32'd12800, 1'b1, 1'b0, 1'b1, 1'b1),
            1, mk_res(sgc_pkg::RES_ERROR, sgc_pkg::MC_ERROR, 1'b0, 1'b1, 1'b0,
                      sgc_pkg::SERVO_2, sgc_pkg::OP_SAVE));
    add_row(centered_tick(32'd14300), 0, '0);
    add_row(rel_tick(32'd15000, 1'b1, 1'b1), 0, '0);
    add_row(rel_tick(32'd15800, 1'b1, 1'b1), 0, '0);
    add_row(save_tick(32'd16000, 1'b1, 1'b1, 1'b1, 1'b1), 0, '0);
    add_row(save_tick(32'd16800, 1'b1, 1'b1, 1'b0, 1'b1),
            1, mk_res(sgc_pkg::RES_ERROR, sgc_pkg::MC_ERROR, 1'b0, 1'b1, 1'b1,
                      sgc_pkg::SERVO_1, sgc_pkg::OP_RESTORE));
    add_row(centered_tick(32'd18300), 0, '0);
    add_row(rel_tick(32'd19000, 1'b1, 1'b1), 0, '0);
    add_row(rel_tick(32'd19800, 1'b1, 1'b1), 0, '0);
    // throttle up while released
    add_row(mk_tick(12'd0, 12'd0, 12'd4095, 12'd0, 1'b1, 1'b0, 32'd20000,
                    1'b1, 1'b1, 1'b1, 1'b1),
            1, mk_res(sgc_pkg::RES_ERROR, sgc_pkg::MC_IDLE, 1'b0, 1'b0, 1'b1,
                      sgc_pkg::SERVO_NONE, sgc_pkg::OP_NONE));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_tick(directed_rows[i].tick, directed_rows[i].typed, directed_rows[i].want);
    tick_ms = 32'd21000;

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        wait_until_drained();
        case (p)
          1: begin
            new_low = 12'd0;
            new_high = 12'd4095;
            new_hold = 16'd0;
            new_ack = 16'd0;
            new_err = 16'd0;
          end
          2: begin
            new_low = 12'd4095;
            new_high = 12'd0;
            new_hold = 16'hFFFF;
            new_ack = 16'hFFFF;
            new_err = 16'hFFFF;
          end
          5: begin
            rnd = $urandom;
            new_low = rnd[11:0];
            new_high = rnd[23:12];
            rnd = $urandom_range(0, 3000);
            new_hold = rnd[15:0];
            rnd = $urandom_range(0, 3000);
            new_ack = rnd[15:0];
            rnd = $urandom_range(0, 3000);
            new_err = rnd[15:0];
          end
          default: begin
            rnd = $urandom_range(600, 1500);
            new_low = rnd[11:0];
            rnd = $urandom_range(1500, 2400);
            new_high = rnd[11:0];
            rnd = $urandom_range(0, 40);
            new_hold = rnd[15:0];
            rnd = $urandom_range(0, 60);
            new_ack = rnd[15:0];
            rnd = $urandom_range(0, 60);
            new_err = rnd[15:0];
          end
        endcase
        rnd = $urandom;
        write_reg(sgc_pkg::REG_LOW_THR, {rnd[15:12], new_low});
        rnd = $urandom;
        write_reg(sgc_pkg::REG_HIGH_THR, {rnd[15:12], new_high});
        write_reg(sgc_pkg::REG_HOLD, new_hold);
        write_reg(sgc_pkg::REG_ACK, new_ack);
        write_reg(sgc_pkg::REG_ERROR, new_err);
        // writes to indexes past the last register are dropped
        if (p % 3 == 0) begin
          spare_idx = REG_FIRST_UNUSED;
          repeat (3) begin
            rnd = $urandom;
            write_reg(spare_idx, rnd[sgc_pkg::CFGW-1:0]);
            spare_idx = spare_idx + 1'b1;
          end
        end
        cfg_we <= 1'b0;
      end
      repeat (PHASE_ITEMS) send_tick(next_random_tick(), 0, '0);
    end

    wait_until_drained();
    repeat (4) @(posedge clk);
    if (mismatch_cnt == 0 && calib_results_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
